/* sv/pmsr_pkg.sv */
// ----------------------------------------------------------------------------
// pmsr_pkg
// Shared types and constants for the presence-mask slot resolver: result
// status codes, mask byte layout and the per-byte mask decode summary.
// ----------------------------------------------------------------------------
package pmsr_pkg;

   // Mask byte layout: seven presence bits, LSB first, then a continue flag
   localparam int MASK_BITS = 7;
   localparam int CONT_BIT  = 7;

   // Field widths
   localparam int SLOT_W   = 6;
   localparam int BASE_W   = 32;
   localparam int OFFSET_W = 33;

   // Result status codes
   typedef enum logic [1:0] {
      ST_FOUND  = 2'd0,
      ST_ABSENT = 2'd1,
      ST_TRUNC  = 2'd2
   } status_type;

   // Summary of one mask byte against the wanted slot
   typedef struct packed {
      logic       decides;      // wanted slot lies in this byte
      logic       present;      // wanted slot's presence bit (valid with decides)
      logic [2:0] below_count;  // present slots in this byte below the wanted slot
   } mask_info_type;

endpackage

/* sv/pmsr_mask_decode.sv */
// ----------------------------------------------------------------------------
// pmsr_mask_decode
// Decodes one presence-mask byte against the wanted slot: whether the slot
// falls in this byte, its presence bit, and how many present slots precede it.
// ----------------------------------------------------------------------------
module pmsr_mask_decode (
   input  logic [6:0]                    mask_bits,
   input  logic [pmsr_pkg::SLOT_W-1:0]   wanted_slot,
   input  logic [pmsr_pkg::SLOT_W-1:0]   byte_slot,
   output pmsr_pkg::mask_info_type       info
);

   logic [pmsr_pkg::SLOT_W-1:0] distance;
   logic                        in_byte;
   logic [2:0]                  position;
   logic [7:0]                  padded_bits;
   logic [6:0]                  below;
   logic [2:0]                  count;

   // Locate the wanted slot relative to this byte's first slot
   assign distance    = wanted_slot - byte_slot;
   assign in_byte     = distance < pmsr_pkg::SLOT_W'(pmsr_pkg::MASK_BITS);
   assign position    = distance[2:0];
   assign padded_bits = {1'b0, mask_bits};

   // Count present slots below the wanted one
   always_comb begin
      count = 3'd0;
      for (int b = 0; b < pmsr_pkg::MASK_BITS; b++) begin
         below[b] = in_byte ? (3'(b) < position) : 1'b1;
         count    = count + 3'(mask_bits[b] & below[b]);
      end
   end

   assign info.decides     = in_byte;
   assign info.present     = padded_bits[position];
   assign info.below_count = count;

endmodule

/* sv/presence_mask_slot_resolver.sv */
// ----------------------------------------------------------------------------
// presence_mask_slot_resolver
// Locates one field of a record from its presence mask and offset table and
// returns the field's absolute offset, or reports it absent or truncated.
// ----------------------------------------------------------------------------
// Feed the record one byte per word, starting at the first mask byte with
// req_tuser (start of record) set; the wanted slot and record base are taken
// from that word. Each word is registered, then decoded and retired into the
// result register, so a word is accepted every cycle unless the result side
// stalls, and a result, when a word produces one, comes from the result
// register. Each byte takes a single mask decode step; the only stall is
// backpressure on the result side. A word carrying start of record aborts
// any query in progress. Words without an active query give no result. A
// word with req_tlast that leaves a query open answers truncated.
// ----------------------------------------------------------------------------
module presence_mask_slot_resolver #(
   parameter int MAX_FIELDS = 64
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // data_byte[7:0], wanted_slot[13:8],
                                    // record_base[45:14], zero[47:46]
   input  logic        req_tuser,   // start_of_record
   input  logic        req_tlast,   // buffer_end

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // field_offset[32:0], zero[39:33]
   output logic [1:0]  rsp_tuser    // status
);

   localparam int SW = pmsr_pkg::SLOT_W;
   localparam int BW = pmsr_pkg::BASE_W;
   localparam int OW = pmsr_pkg::OFFSET_W;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_MASK     = 3'd1,
      PH_SKIPMASK = 3'd2,
      PH_TABLE    = 3'd3,
      PH_HIGH     = 3'd4
   } phase_type;

   // Input register
   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff;
   logic          in_start_ff;
   logic [SW-1:0] in_slot_ff;
   logic [BW-1:0] in_base_ff;
   logic          in_last_ff;

   // Query state
   phase_type     phase_ff, phase_in;
   logic [SW-1:0] byte_slot_ff, byte_slot_in;
   logic [SW-1:0] present_below_ff, present_below_in;
   logic [6:0]    skip_ff, skip_in;
   logic [7:0]    low_byte_ff, low_byte_in;
   logic [SW-1:0] held_slot_ff, held_slot_in;
   logic [BW-1:0] held_base_ff, held_base_in;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   pmsr_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [OW-1:0]        rsp_offset_ff, rsp_offset_in;

   // Working values
   phase_type               cur_phase;
   logic [SW-1:0]           cur_byte_slot;
   logic [SW-1:0]           cur_present_below;
   logic [6:0]              cur_skip;
   logic [7:0]              cur_low_byte;
   logic [SW-1:0]           cur_slot;
   logic [BW-1:0]           cur_base;
   logic [SW-1:0]           below_sum;
   logic                    item_fire;
   logic                    answer;
   logic                    query_open;
   pmsr_pkg::status_type    answer_status;
   logic [OW-1:0]           answer_offset;
   pmsr_pkg::mask_info_type mask_info;

   // Advance the item stage only when the result register can take its answer
   assign item_fire  = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || item_fire;

   // Start of record reloads the query from the item itself
   always_comb begin
      if (in_start_ff) begin
         cur_phase         = PH_MASK;
         cur_byte_slot     = '0;
         cur_present_below = '0;
         cur_skip          = '0;
         cur_low_byte      = '0;
         cur_slot          = in_slot_ff;
         cur_base          = in_base_ff;
      end else begin
         cur_phase         = phase_ff;
         cur_byte_slot     = byte_slot_ff;
         cur_present_below = present_below_ff;
         cur_skip          = skip_ff;
         cur_low_byte      = low_byte_ff;
         cur_slot          = held_slot_ff;
         cur_base          = held_base_ff;
      end
   end

   pmsr_mask_decode u_mask_decode (
      .mask_bits   (in_byte_ff[6:0]),
      .wanted_slot (cur_slot),
      .byte_slot   (cur_byte_slot),
      .info        (mask_info)
   );

   assign below_sum = cur_present_below + SW'(mask_info.below_count);

   // Step the query by one byte
   always_comb begin
      phase_in         = cur_phase;
      byte_slot_in     = cur_byte_slot;
      present_below_in = cur_present_below;
      skip_in          = cur_skip;
      low_byte_in      = cur_low_byte;
      held_slot_in     = cur_slot;
      held_base_in     = cur_base;
      answer           = 1'b0;
      query_open       = 1'b0;
      answer_status    = pmsr_pkg::ST_FOUND;
      answer_offset    = '0;

      if (in_start_ff && ({1'b0, in_slot_ff} >= (SW + 1)'(MAX_FIELDS))) begin
         answer        = 1'b1;
         answer_status = pmsr_pkg::ST_ABSENT;
      end else begin
         unique case (cur_phase)
            PH_IDLE: begin
            end
            PH_MASK: begin
               query_open = 1'b1;
               if (mask_info.decides && !mask_info.present) begin
                  answer        = 1'b1;
                  answer_status = pmsr_pkg::ST_ABSENT;
               end else if (mask_info.decides) begin
                  present_below_in = below_sum;
                  skip_in          = {below_sum, 1'b0};
                  phase_in = in_byte_ff[pmsr_pkg::CONT_BIT] ? PH_SKIPMASK : PH_TABLE;
               end else if (!in_byte_ff[pmsr_pkg::CONT_BIT]) begin
                  answer        = 1'b1;
                  answer_status = pmsr_pkg::ST_ABSENT;
               end else begin
                  present_below_in = below_sum;
                  byte_slot_in     = cur_byte_slot + SW'(pmsr_pkg::MASK_BITS);
               end
            end
            PH_SKIPMASK: begin
               query_open = 1'b1;
               if (!in_byte_ff[pmsr_pkg::CONT_BIT]) begin
                  phase_in = PH_TABLE;
               end
            end
            PH_TABLE: begin
               query_open = 1'b1;
               if (cur_skip != 7'd0) begin
                  skip_in = cur_skip - 7'd1;
               end else begin
                  low_byte_in = in_byte_ff;
                  phase_in    = PH_HIGH;
               end
            end
            PH_HIGH: begin
               answer        = 1'b1;
               answer_status = pmsr_pkg::ST_FOUND;
               answer_offset = OW'(cur_base) + OW'({in_byte_ff, cur_low_byte});
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      // Close an open query at the end of the buffer
      if (!answer && query_open && in_last_ff) begin
         answer        = 1'b1;
         answer_status = pmsr_pkg::ST_TRUNC;
      end
      if (answer) begin
         phase_in = PH_IDLE;
      end
   end

   // Load or drain the input register and the result register
   always_comb begin
      in_valid_in   = in_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (item_fire) begin
         in_valid_in = 1'b0;
      end
      if (item_fire) begin
         rsp_valid_in  = answer;
         rsp_status_in = answer_status;
         rsp_offset_in = answer_offset;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         phase_ff         <= PH_IDLE;
         byte_slot_ff     <= '0;
         present_below_ff <= '0;
         skip_ff          <= '0;
         low_byte_ff      <= '0;
         held_slot_ff     <= '0;
         held_base_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (item_fire) begin
            phase_ff         <= phase_in;
            byte_slot_ff     <= byte_slot_in;
            present_below_ff <= present_below_in;
            skip_ff          <= skip_in;
            low_byte_ff      <= low_byte_in;
            held_slot_ff     <= held_slot_in;
            held_base_ff     <= held_base_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata[7:0];
         in_slot_ff  <= req_tdata[13:8];
         in_base_ff  <= req_tdata[45:14];
         in_start_ff <= req_tuser;
         in_last_ff  <= req_tlast;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_offset_ff};
   assign rsp_tuser  = rsp_status_ff;

   // Offset is zero on every answer other than found
   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != pmsr_pkg::ST_FOUND) |-> rsp_offset_ff == '0)
      else $error("nonzero offset on a not-found answer");

   // The high offset byte always yields a found answer
   a_high_found: assert property (@(posedge clock) disable iff (reset)
      item_fire && !in_start_ff && (phase_ff == PH_HIGH)
      |=> rsp_valid_ff && (rsp_status_ff == pmsr_pkg::ST_FOUND))
      else $error("high offset byte did not produce a found answer");

   // Any answer closes the query
   a_answer_idle: assert property (@(posedge clock) disable iff (reset)
      item_fire && answer |=> phase_ff == PH_IDLE)
      else $error("query still open after an answer");

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for presence_mask_slot_resolver. Record bytes are
// streamed in as words, directed cases first and then random records (mostly
// well formed, some cut short, abandoned or padded with stray bytes). A
// behavioral resolver tracks every accepted word and queues the answer each
// word should produce; every result word is checked in order against it.
// Sender bursts and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_FIELDS   = 64;
   localparam int SETTLE_WAIT  = 8;       // cycles past the last answer
   localparam int DRAIN_LIMIT  = 20000;   // cycles allowed for answers to come

   // One record byte with its side information
   typedef struct packed {
      logic [7:0]  data;
      logic        sor;
      logic [5:0]  slot;
      logic [31:0] base;
      logic        last;
   } req_word_type;

   // One answer of the resolver
   typedef struct packed {
      pmsr_pkg::status_type status;
      logic [32:0]          offset;
   } offset_answer_type;

   typedef enum logic [2:0] {
      RS_IDLE, RS_MASK, RS_SKIP_MASK, RS_TABLE, RS_HIGH
   } resolve_phase_type;

   typedef enum int {
      SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_SLOW
   } sink_mode_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // data_byte[7:0], wanted_slot[13:8],
                                   // record_base[45:14], zero[47:46]
   logic        req_tuser  = 1'b0; // start_of_record
   logic        req_tlast  = 1'b0; // buffer_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // field_offset[32:0], zero[39:33]
   logic [1:0]  rsp_tuser;         // status

   presence_mask_slot_resolver #(
      .MAX_FIELDS(MAX_FIELDS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Resolver state as the bench sees it
   // ------------------------------------------------------------------------
   resolve_phase_type r_phase     = RS_IDLE;
   logic [6:0]        r_slot_base = '0;
   logic [5:0]        r_below     = '0;
   logic              r_located   = 1'b0;
   logic [6:0]        r_skip      = '0;
   logic [7:0]        r_low       = '0;
   logic [5:0]        r_slot      = '0;
   logic [31:0]       r_base      = '0;

   offset_answer_type pending_offsets[$];

   int fail_count   = 0;
   int words_sent   = 0;
   int record_words = 0;
   int seen_found   = 0;
   int seen_absent  = 0;
   int seen_trunc   = 0;

   // Traffic shape
   sink_mode_type sink_mode  = SINK_OPEN;
   int            gap_max    = 0;
   int            burst_max  = 8;
   int            burst_left = 0;
   logic [7:0]    sink_tick  = '0;

   // Hard stop well past the slowest legal run
   initial begin
      #3_000_000;
      $display("timeout: %0d answers still outstanding", pending_offsets.size());
      $display("tb: FAIL");
      $finish;
   end

   // Advance the resolver by one accepted word; report the answer it gives
   task automatic resolve_byte(input req_word_type w, output bit emits,
                               output offset_answer_type ans);
      int idx;
      bit done;
      emits      = 1'b0;
      done       = 1'b0;
      ans.status = pmsr_pkg::ST_FOUND;
      ans.offset = '0;
      if (w.sor) begin
         r_phase     = RS_MASK;
         r_slot_base = '0;
         r_below     = '0;
         r_located   = 1'b0;
         r_skip      = '0;
         r_low       = '0;
         r_slot      = w.slot;
         r_base      = w.base;
         if (int'(r_slot) >= MAX_FIELDS) begin
            emits = 1'b1; ans.status = pmsr_pkg::ST_ABSENT; r_phase = RS_IDLE;
            done = 1'b1;
         end
      end
      if (!done) begin
         case (r_phase)
            RS_MASK: begin
               // walk the seven presence bits of this mask byte
               for (int b = 0; b < pmsr_pkg::MASK_BITS && !done; b++) begin
                  idx = int'(r_slot_base) + b;
                  if (idx == int'(r_slot)) begin
                     if (!w.data[b]) begin
                        emits = 1'b1; ans.status = pmsr_pkg::ST_ABSENT;
                        r_phase = RS_IDLE;
                        done = 1'b1;
                     end else begin
                        r_located = 1'b1;
                     end
                  end else if (idx < int'(r_slot) && w.data[b]) begin
                     r_below = r_below + 6'd1;
                  end
               end
               if (!done) begin
                  if (r_located) begin
                     r_skip  = {r_below, 1'b0};
                     r_phase = w.data[pmsr_pkg::CONT_BIT] ? RS_SKIP_MASK : RS_TABLE;
                  end else if (!w.data[pmsr_pkg::CONT_BIT]) begin
                     emits = 1'b1; ans.status = pmsr_pkg::ST_ABSENT; r_phase = RS_IDLE;
                     done = 1'b1;
                  end else begin
                     r_slot_base = r_slot_base + 7'd7;
                  end
               end
            end
            RS_SKIP_MASK: begin
               if (!w.data[pmsr_pkg::CONT_BIT]) r_phase = RS_TABLE;
            end
            RS_TABLE: begin
               if (r_skip != 7'd0) begin
                  r_skip = r_skip - 7'd1;
               end else begin
                  r_low   = w.data;
                  r_phase = RS_HIGH;
               end
            end
            RS_HIGH: begin
               emits      = 1'b1;
               ans.status = pmsr_pkg::ST_FOUND;
               ans.offset = {1'b0, r_base} + {17'd0, w.data, r_low};
               r_phase    = RS_IDLE;
               done       = 1'b1;
            end
            default: begin
               // no query open: the byte is dropped
               r_phase = RS_IDLE;
               done    = 1'b1;
            end
         endcase
         if (!done && w.last) begin
            emits = 1'b1; ans.status = pmsr_pkg::ST_TRUNC; r_phase = RS_IDLE;
         end
      end
   endtask

   task automatic note_failure(input string what, input offset_answer_type want,
                               input offset_answer_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t %s: expected status %0d offset %h, got status %0d offset %h",
                  $realtime, what, want.status, want.offset, got.status, got.offset);
   endtask

   // Check result words and predict from request words, both at the edge
   always @(posedge clock) begin : watch
      req_word_type      w;
      offset_answer_type got;
      offset_answer_type want;
      offset_answer_type pred;
      bit                emits;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = pmsr_pkg::status_type'(rsp_tuser);
            got.offset = rsp_tdata[32:0];
            if (pending_offsets.size() == 0) begin
               note_failure("unexpected result", '0, got);
            end else begin
               want = pending_offsets.pop_front();
               if (got.status !== want.status || got.offset !== want.offset)
                  note_failure("mismatch", want, got);
               case (want.status)
                  pmsr_pkg::ST_FOUND:  seen_found++;
                  pmsr_pkg::ST_ABSENT: seen_absent++;
                  default:             seen_trunc++;
               endcase
            end
         end
         if (req_tvalid && req_tready) begin
            w = {req_tdata[7:0], req_tuser, req_tdata[13:8], req_tdata[45:14],
                 req_tlast};
            resolve_byte(w, emits, pred);
            if (emits) pending_offsets.push_back(pred);
         end
      end
   end

   // Result side backpressure
   always @(posedge clock) begin
      sink_tick <= sink_tick + 8'd1;
      case (sink_mode)
         SINK_OPEN:     rsp_tready <= 1'b1;
         SINK_RANDOM:   rsp_tready <= ($urandom_range(0, 99) < 60);
         SINK_PERIODIC: rsp_tready <= (sink_tick[2:0] < 3'd3);
         default:       rsp_tready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   function automatic req_word_type make_word(input logic [7:0] data, input logic sor,
                                              input logic [5:0] slot,
                                              input logic [31:0] base,
                                              input logic last);
      req_word_type w;
      w.data = data;
      w.sor  = sor;
      w.slot = slot;
      w.base = base;
      w.last = last;
      return w;
   endfunction

   task automatic set_traffic(input sink_mode_type mode, input int gmax, input int bmax);
      sink_mode  = mode;
      gap_max    = gmax;
      burst_max  = bmax;
      burst_left = 0;
   endtask

   // Send one word, idling between bursts, and hold it until taken
   task automatic send_word(input req_word_type w);
      int gap;
      if (burst_left == 0) begin
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, burst_max);
      end
      burst_left--;
      req_tdata  <= {2'b00, w.base, w.slot, w.data};
      req_tuser  <= w.sor;
      req_tlast  <= w.last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   // Stop sending until every expected answer has come, then settle
   task automatic wait_for_answers();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_offsets.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      while (pending_offsets.size() != 0)
         note_failure("missing result", pending_offsets.pop_front(), '0);
      repeat (SETTLE_WAIT) @(posedge clock);
      burst_left = 0;
   endtask

   // ------------------------------------------------------------------------
   // Directed cases
   // ------------------------------------------------------------------------

   // Largest base plus largest table offset carries into bit 32
   task automatic test_offset_carry();
      set_traffic(SINK_OPEN, 0, 8);
      send_word(make_word(8'h01, 1'b1, 6'd0, 32'hFFFF_FFFF, 1'b0));
      send_word(make_word(8'hFF, 1'b0, 6'd63, 32'h0, 1'b0));
      send_word(make_word(8'hFF, 1'b0, 6'd0, 32'h0, 1'b0));
      wait_for_answers();
   endtask

   // Bytes with no query open give nothing, even with buffer end
   task automatic test_idle_bytes();
      set_traffic(SINK_RANDOM, 2, 2);
      send_word(make_word(8'h81, 1'b0, 6'd5, 32'h1234_5678, 1'b0));
      send_word(make_word(8'h00, 1'b0, 6'd0, 32'h0, 1'b1));
      wait_for_answers();
   endtask

   // Clear bit (with buffer end on the same byte), mask ending early,
   // and the top presence bit of a later mask byte
   task automatic test_absent_cases();
      set_traffic(SINK_PERIODIC, 1, 3);
      send_word(make_word(8'h77, 1'b1, 6'd3, 32'hA5A5_A5A5, 1'b1));
      send_word(make_word(8'h7F, 1'b1, 6'd20, 32'h5A5A_5A5A, 1'b0));
      send_word(make_word(8'h80, 1'b1, 6'd13, 32'h0000_0001, 1'b0));
      send_word(make_word(8'h3F, 1'b0, 6'd0, 32'h0, 1'b0));
      wait_for_answers();
   endtask

   // Buffer ends inside the mask, then inside the offset table
   task automatic test_truncation();
      set_traffic(SINK_SLOW, 0, 4);
      send_word(make_word(8'h83, 1'b1, 6'd1, 32'h0000_8000, 1'b1));
      send_word(make_word(8'h01, 1'b1, 6'd0, 32'h0001_0000, 1'b0));
      send_word(make_word(8'h44, 1'b0, 6'd0, 32'h0, 1'b1));
      wait_for_answers();
   endtask

   // A new start aborts the query in flight without an answer
   task automatic test_restart();
      set_traffic(SINK_OPEN, 0, 8);
      send_word(make_word(8'h87, 1'b1, 6'd2, 32'hDEAD_0000, 1'b0));
      send_word(make_word(8'h01, 1'b1, 6'd0, 32'h0000_0000, 1'b0));
      send_word(make_word(8'h34, 1'b0, 6'd0, 32'h0, 1'b0));
      send_word(make_word(8'h12, 1'b0, 6'd0, 32'h0, 1'b0));
      wait_for_answers();
   endtask

   // Slot in the second mask byte: skip a third mask byte and two entries
   task automatic test_skip_paths();
      set_traffic(SINK_RANDOM, 3, 2);
      send_word(make_word(8'h85, 1'b1, 6'd9, 32'h0000_1000, 1'b0));
      send_word(make_word(8'h8C, 1'b0, 6'd0, 32'h0, 1'b0));
      send_word(make_word(8'h00, 1'b0, 6'd0, 32'h0, 1'b0));
      send_word(make_word(8'hAA, 1'b0, 6'd0, 32'h0, 1'b0));
      send_word(make_word(8'h55, 1'b0, 6'd0, 32'h0, 1'b0));
      send_word(make_word(8'h00, 1'b0, 6'd0, 32'h0, 1'b0));
      send_word(make_word(8'hFF, 1'b0, 6'd0, 32'h0, 1'b0));
      send_word(make_word(8'h34, 1'b0, 6'd0, 32'h0, 1'b0));
      send_word(make_word(8'h12, 1'b0, 6'd0, 32'h0, 1'b0));
      wait_for_answers();
   endtask

   // ------------------------------------------------------------------------
   // Random records: mask, matching table, occasional damage and stray bytes
   // ------------------------------------------------------------------------
   task automatic test_random_records(input int target);
      req_word_type rec[$];
      req_word_type w;
      logic [7:0]   mask;
      logic [5:0]   slot;
      logic [31:0]  base;
      int           n_mask, below, cut, roll, first_count, pos;
      bit           located, dense;
      first_count = record_words;
      set_traffic(SINK_OPEN, 0, 16);
      while (record_words - first_count < target) begin
         // reshape traffic now and then
         if ($urandom_range(0, 24) == 0)
            set_traffic(sink_mode_type'($urandom_range(0, 3)), $urandom_range(0, 6),
                        $urandom_range(1, 16));
         rec.delete();
         if ($urandom_range(0, 99) < 85) slot = 6'($urandom_range(0, 13));
         else                            slot = 6'($urandom_range(14, 63));
         base    = $urandom();
         dense   = ($urandom_range(0, 4) == 0);
         n_mask  = int'(slot) / 7 + 1 + $urandom_range(0, 2);
         if ($urandom_range(0, 9) == 0) n_mask = $urandom_range(1, int'(slot) / 7 + 1);
         below   = 0;
         located = 1'b0;

         // mask bytes, continue flag on all but the last
         for (int m = 0; m < n_mask; m++) begin
            mask = 8'($urandom());
            if (dense) mask[6:0] = 7'h7F;
            mask[pmsr_pkg::CONT_BIT] = (m != n_mask - 1);
            for (int b = 0; b < pmsr_pkg::MASK_BITS; b++) begin
               pos = m * pmsr_pkg::MASK_BITS + b;
               if (pos == int'(slot)) begin
                  if ($urandom_range(0, 9) < 8) mask[b] = 1'b1;
                  located = mask[b];
               end else if (pos < int'(slot) && mask[b]) begin
                  below++;
               end
            end
            if (m == 0) rec.push_back(make_word(mask, 1'b1, slot, base, 1'b0));
            else        rec.push_back(make_word(mask, 1'b0, 6'($urandom()), $urandom(),
                                                1'b0));
         end

         // skipped table entries plus the wanted offset
         if (located)
            for (int t = 0; t < 2 * below + 2; t++)
               rec.push_back(make_word(8'($urandom()), 1'b0, 6'($urandom()),
                                       $urandom(), 1'b0));

         // damage: cut short at buffer end, abandon, or flag end on the last byte
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            cut = $urandom_range(0, rec.size() - 1);
            while (rec.size() > cut + 1) void'(rec.pop_back());
            w = rec.pop_back();
            w.last = 1'b1;
            rec.push_back(w);
         end else if (roll < 13) begin
            cut = $urandom_range(1, rec.size());
            while (rec.size() > cut) void'(rec.pop_back());
         end else if (roll < 17) begin
            w = rec.pop_back();
            w.last = 1'b1;
            rec.push_back(w);
         end

         foreach (rec[i]) begin
            send_word(rec[i]);
            record_words++;
         end

         // stray bytes between records
         if ($urandom_range(0, 19) == 0)
            repeat ($urandom_range(1, 3))
               send_word(make_word(8'($urandom()), 1'b0, 6'($urandom()), $urandom(),
                                   1'($urandom_range(0, 1))));

         if ($urandom_range(0, 49) == 0) wait_for_answers();
      end
      wait_for_answers();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_idle_bytes();
      test_offset_carry();
      test_absent_cases();
      test_truncation();
      test_restart();
      test_skip_paths();
      test_random_records(700);
      $display("summary: %0d words sent, %0d of them in random records", words_sent,
               record_words);
      $display("summary: answers checked: %0d found, %0d absent, %0d truncated",
               seen_found, seen_absent, seen_trunc);
      if (fail_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("%0d failures", fail_count);
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
